/* rtl/assert_macros.svh */
// Assertion macros shared by the SHA-256 hasher RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every clock, off during reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition followed by a consequence on the next clock
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sha256_pkg.sv */
// Package for the SHA-256 byte stream hasher: payload types, control struct,
// round constants, initial hash values and round functions. No dependencies.
`default_nettype none

package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // control from the sequencer to the round datapath
  typedef struct packed {
    logic       load_en;
    logic [2:0] load_idx;
    logic       round_en;
    logic [5:0] ridx;
  } round_ctl_t;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sm_s0(input logic [31:0] x);
    sm_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sm_s1(input logic [31:0] x);
    sm_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

/* rtl/sha256_hmem.sv */
// Chained hash word memory, 8 x 32, registered read.
// Per-entry valid bits make unwritten entries read as the initial values.
// Depends on sha256_pkg.
`default_nettype none

module sha256_hmem (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [2:0]  raddr,
  output logic      [31:0] rdata,
  input  wire logic        we,
  input  wire logic [2:0]  waddr,
  input  wire logic [31:0] wdata,
  input  wire logic        clear
);

  logic [31:0] mem [8];
  logic [7:0]  vld_r;
  logic [31:0] rdata_r;

  // storage and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= vld_r[raddr] ? mem[raddr] : sha256_pkg::IV[raddr];
  end

  // valid bits: reset and clear return every entry to its initial value
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/sha256_round.sv */
// Compression round datapath: working variables a..h and the 16-word
// message schedule window. Depends on sha256_pkg.
`default_nettype none

module sha256_round (
  input  wire logic                   clk,
  input  wire sha256_pkg::round_ctl_t ctl,
  input  wire logic [31:0]            hm_rdata,
  input  wire logic [31:0]            buf_rdata,
  output logic [7:0][31:0]            work
);

  logic [7:0][31:0]  v_r;
  logic [15:0][31:0] win_r;
  logic [31:0]       w_cur;
  logic [31:0]       t1;
  logic [31:0]       t2;
  logic [31:0]       ch;
  logic [31:0]       maj;

  // schedule word: block words first, then the recurrence
  always_comb begin
    if (ctl.ridx[5:4] == 2'b00) begin
      w_cur = buf_rdata;
    end else begin
      w_cur = win_r[0] + sha256_pkg::sm_s0(win_r[1]) + win_r[9]
            + sha256_pkg::sm_s1(win_r[14]);
    end
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1  = v_r[7] + sha256_pkg::big_s1(v_r[4]) + ch + sha256_pkg::RK[ctl.ridx] + w_cur;
    t2  = sha256_pkg::big_s0(v_r[0]) + maj;
  end

  // working variables and window update
  always_ff @(posedge clk) begin
    if (ctl.load_en) begin
      v_r[ctl.load_idx] <= hm_rdata;
    end else if (ctl.round_en) begin
      v_r   <= {v_r[6:4], v_r[3] + t1, v_r[2:0], t1 + t2};
      win_r <= {w_cur, win_r[15:1]};
    end
  end

  assign work = v_r;

endmodule

`default_nettype wire

/* rtl/sha256_byte_stream_hasher_unit.sv */
// Channel | dir | payload            | handshake
// in_     | in  | sha256_pkg::in_item_t  | in_valid / in_stall
// out_    | out | sha256_pkg::out_item_t | out_valid / out_stall
//
// A byte item is taken while the sequencer is idle; the 64th byte of a block adds
// a compression: hash loads, 64 rounds, read-add-write in the hash memory.
// End of message: one pad byte per cycle plus compressions, then each digest word
// is read, captured and output, held while out_stall is high.
// Reset (synchronous, rst_n low) clears control and the hash valid bits.
// in_stall is high whenever the sequencer is not idle.
// Top level: sequencer, block buffer memory, bit counter. Depends on
// sha256_pkg, sha256_hmem, sha256_round and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sha256_byte_stream_hasher_unit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire sha256_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output sha256_pkg::out_item_t      out_data
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b00000001,
    ST_LOAD     = 8'b00000010,
    ST_ROUND    = 8'b00000100,
    ST_UPDATE   = 8'b00001000,
    ST_PAD      = 8'b00010000,
    ST_EMIT_RD  = 8'b00100000,
    ST_EMIT_CAP = 8'b01000000,
    ST_EMIT_OUT = 8'b10000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bitcnt_r, bitcnt_nxt;
  logic        pad_r, pad_nxt;
  logic        sent80_r, sent80_nxt;
  logic [3:0]  lcnt_r, lcnt_nxt;
  logic        ov_r, ov_nxt;
  sha256_pkg::out_item_t od_r;

  logic        push_en;
  logic [7:0]  push_byte;
  logic        in_len;
  logic        in_acc;
  logic        out_acc;

  logic [31:0] buf_mem [16];
  logic [3:0]  buf_raddr;
  logic [31:0] buf_rdata_r;

  logic [2:0]  hm_raddr;
  logic [31:0] hm_rdata;
  logic        hm_we;
  logic [2:0]  hm_waddr;
  logic [31:0] hm_wdata;
  logic        hm_clear;

  sha256_pkg::round_ctl_t rctl;
  logic [7:0][31:0]       work;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = ov_r && !out_stall;
  assign in_len   = (lcnt_r != 4'd0) || (sent80_r && fill_r == sha256_pkg::LEN_START);

  // byte source: message byte when idle, pad or length byte when padding
  always_comb begin
    push_en   = 1'b0;
    push_byte = in_data.data_byte;
    if (state_r == ST_IDLE) begin
      push_en = in_acc && in_data.byte_valid;
    end else if (state_r == ST_PAD) begin
      push_en = 1'b1;
      if (!sent80_r) begin
        push_byte = sha256_pkg::PAD_MARK;
      end else if (in_len) begin
        push_byte = 8'(bitcnt_r >> {~lcnt_r[2:0], 3'b000});
      end else begin
        push_byte = 8'h00;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    fill_nxt   = push_en ? fill_r + 6'd1 : fill_r;
    bitcnt_nxt = bitcnt_r;
    pad_nxt    = pad_r;
    sent80_nxt = sent80_r;
    lcnt_nxt   = lcnt_r;
    ov_nxt     = ov_r;
    hm_raddr   = cnt_r[2:0];
    hm_we      = 1'b0;
    hm_waddr   = 3'(cnt_r - 7'd1);
    hm_wdata   = hm_rdata + work[hm_waddr];
    hm_clear   = 1'b0;
    buf_raddr  = 4'd0;
    rctl       = '0;
    rctl.ridx  = cnt_r[5:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.byte_valid) begin
            bitcnt_nxt = bitcnt_r + 64'd8;
          end
          pad_nxt = in_data.end_of_message;
          cnt_nxt = '0;
          if (in_data.byte_valid && fill_r == 6'd63) begin
            state_nxt = ST_LOAD;
          end else if (in_data.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        sent80_nxt = 1'b1;
        if (sent80_r && in_len) begin
          lcnt_nxt = lcnt_r + 4'd1;
        end
        if (fill_r == 6'd63) begin
          cnt_nxt   = '0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        rctl.load_en  = (cnt_r != 7'd0);
        rctl.load_idx = hm_waddr;
        cnt_nxt       = cnt_r + 7'd1;
        if (cnt_r == 7'd8) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        rctl.round_en = 1'b1;
        buf_raddr     = 4'(cnt_r + 7'd1);
        cnt_nxt       = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          cnt_nxt   = '0;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        hm_we   = (cnt_r != 7'd0);
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd8) begin
          cnt_nxt = '0;
          if (!pad_r) begin
            state_nxt = ST_IDLE;
          end else if (lcnt_r == 4'd8) begin
            state_nxt = ST_EMIT_RD;
          end else begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_CAP;
      end
      ST_EMIT_CAP: begin
        ov_nxt    = 1'b1;
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          if (cnt_r == 7'd7) begin
            hm_clear   = 1'b1;
            fill_nxt   = '0;
            bitcnt_nxt = '0;
            pad_nxt    = 1'b0;
            sent80_nxt = 1'b0;
            lcnt_nxt   = '0;
            cnt_nxt    = '0;
            state_nxt  = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 7'd1;
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      fill_r   <= '0;
      bitcnt_r <= '0;
      pad_r    <= 1'b0;
      sent80_r <= 1'b0;
      lcnt_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      fill_r   <= fill_nxt;
      bitcnt_r <= bitcnt_nxt;
      pad_r    <= pad_nxt;
      sent80_r <= sent80_nxt;
      lcnt_r   <= lcnt_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT_CAP) begin
      od_r.digest_word <= hm_rdata;
      od_r.word_index  <= cnt_r[2:0];
      od_r.last_word   <= (cnt_r == 7'd7);
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  // block buffer: 16 big-endian words, byte-lane writes
  always_ff @(posedge clk) begin
    if (push_en) begin
      buf_mem[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= push_byte;
    end
    buf_rdata_r <= buf_mem[buf_raddr];
  end

  sha256_hmem u_hmem (
    .clk   (clk),
    .rst_n (rst_n),
    .raddr (hm_raddr),
    .rdata (hm_rdata),
    .we    (hm_we),
    .waddr (hm_waddr),
    .wdata (hm_wdata),
    .clear (hm_clear)
  );

  sha256_round u_round (
    .clk       (clk),
    .ctl       (rctl),
    .hm_rdata  (hm_rdata),
    .buf_rdata (buf_rdata_r),
    .work      (work)
  );

  `ASSERT_CLK(a_out_state, !ov_r || state_r == ST_EMIT_OUT, "output valid outside emit")
  `ASSERT_CLK(a_len_count, lcnt_r <= 4'd8, "length byte count overrun")
  `ASSERT_NEXT(a_eom_busy, in_acc && in_data.end_of_message, state_r != ST_IDLE, "end item ignored")
  `ASSERT_NEXT(a_last_done, out_acc && od_r.last_word, state_r == ST_IDLE && fill_r == 6'd0, "no restart after digest")

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Testbench for sha256_byte_stream_hasher_unit: drives byte items, predicts
// each digest with a SHA-256 model of its own and checks every output word.
// Depends on sha256_pkg and the RTL of the hasher.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  sha256_pkg::in_item_t  in_data;
  logic                  out_valid;
  logic                  out_stall;
  sha256_pkg::out_item_t out_data;

  sha256_byte_stream_hasher_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Predictor state: chained hash, block bytes, fill level, message length
  logic [31:0] chain_h [8];
  logic [7:0]  blk [64];
  int unsigned blk_fill;
  logic [63:0] msg_bits;

  sha256_pkg::in_item_t  pending_items [$];
  sha256_pkg::out_item_t digest_fifo [$];
  int        fail_cnt;
  bit        stim_done;
  bit        hold_req;
  logic      in_taken;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_reset();
    for (int i = 0; i < 8; i++) chain_h[i] = sha256_pkg::IV[i];
    blk_fill = 0;
    msg_bits = '0;
  endtask

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + sha256_pkg::RK[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endtask

  task automatic add_byte(logic [7:0] b);
    blk[blk_fill] = b;
    blk_fill++;
    if (blk_fill == 64) begin
      compress();
      blk_fill = 0;
    end
  endtask

  // Apply one accepted item; queue the eight digest words on end of message
  task automatic predict_item(sha256_pkg::in_item_t it);
    logic [63:0]           len;
    sha256_pkg::out_item_t o;
    if (it.byte_valid) begin
      msg_bits += 64'd8;
      add_byte(it.data_byte);
    end
    if (it.end_of_message) begin
      len = msg_bits;
      add_byte(sha256_pkg::PAD_MARK);
      while (blk_fill != sha256_pkg::LEN_START) add_byte(8'h00);
      for (int k = 0; k < 8; k++) add_byte(len[63 - 8*k -: 8]);
      for (int k = 0; k < 8; k++) begin
        o.digest_word    = chain_h[k];
        o.word_index     = k[2:0];
        o.last_word      = (k == 7);
        digest_fifo.push_back(o);
      end
      hash_reset();
    end
  endtask

  function automatic sha256_pkg::in_item_t mk(logic [7:0] b, logic v, logic e);
    sha256_pkg::in_item_t it;
    it.data_byte = b; it.byte_valid = v; it.end_of_message = e;
    return it;
  endfunction

  // Queue a message of n random bytes, ending with the last byte or alone
  task automatic push_msg(int n, bit noise);
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 9) == 0)
        pending_items.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      if (i == n - 1 && $urandom_range(0, 1))
        pending_items.push_back(mk(8'($urandom_range(0, 255)), 1'b1, 1'b1));
      else begin
        pending_items.push_back(mk(8'($urandom_range(0, 255)), 1'b1, 1'b0));
        if (i == n - 1)
          pending_items.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
      end
    end
    if (n == 0) pending_items.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));
  endtask

  // Stimulus
  initial begin
    int total;
    hash_reset();
    fail_cnt = 0;
    stim_done = 0;
    // empty message, byte with end, idle item, extreme bytes
    pending_items.push_back(mk(8'h00, 1'b0, 1'b1));
    pending_items.push_back(mk(8'hff, 1'b0, 1'b0));
    pending_items.push_back(mk(8'hff, 1'b1, 1'b1));
    pending_items.push_back(mk(8'h00, 1'b1, 1'b0));
    pending_items.push_back(mk(8'hab, 1'b0, 1'b0));
    pending_items.push_back(mk(8'h55, 1'b1, 1'b1));
    pending_items.push_back(mk(8'haa, 1'b1, 1'b0));
    pending_items.push_back(mk(8'h00, 1'b0, 1'b1));
    // lengths around the padding boundary and a full block: 55, 56, 64
    push_msg(55, 0);
    push_msg(56, 0);
    push_msg(64, 0);
    total = 0;
    while (total < 300) begin
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      total += n + 1;
      push_msg(n, 1);
    end
    stim_done = 1;
  end

  // Driver: hold each item until accepted, random gaps between items
  int gap_cnt;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_cnt  <= $urandom_range(0, 10);
    end else if (!in_valid || in_taken) begin
      // prior item accepted at last posedge, or nothing offered
      if (in_valid || gap_cnt == 0) begin
        if (in_valid) gap_cnt <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
        if ((!in_valid || gap_cnt == 0) && pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else
          in_valid <= 1'b0;
      end else
        gap_cnt <= gap_cnt - 1;
    end
  end

  // Receiver stall: random per word, plus one long hold-off early in the run
  int stall_cnt;
  int hold_cnt;
  int words_seen;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cnt <= 0;
      hold_cnt  <= 0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_cnt  <= LONG_HOLD;
    end else if (stall_cnt > 0) begin
      out_stall <= 1'b1;
      stall_cnt <= stall_cnt - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid) stall_cnt <= (words_seen % 97 < 40) ? 0 : $urandom_range(0, 10);
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
      words_seen  <= 0;
      hold_req    <= 1'b0;
      in_taken    <= 1'b0;
    end else begin
      hold_req <= (words_seen == 40) && out_valid && !out_stall;
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) predict_item(in_data);
      if (out_valid && !out_stall) begin
        words_seen <= words_seen + 1;
        if (digest_fifo.size() == 0) begin
          $error("unexpected digest word %h", out_data.digest_word);
          fail_cnt++;
        end else begin
          sha256_pkg::out_item_t exp_w;
          exp_w = digest_fifo.pop_front();
          if (out_data.digest_word !== exp_w.digest_word) begin
            $error("digest_word: expected %h, got %h", exp_w.digest_word,
                   out_data.digest_word);
            fail_cnt++;
          end
          if (out_data.word_index !== exp_w.word_index) begin
            $error("word_index: expected %0d, got %0d", exp_w.word_index,
                   out_data.word_index);
            fail_cnt++;
          end
          if (out_data.last_word !== exp_w.last_word) begin
            $error("last_word: expected %0b, got %0b", exp_w.last_word,
                   out_data.last_word);
            fail_cnt++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, wait for the end of traffic, report
  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        wait (stim_done && pending_items.size() == 0 && !in_valid
              && digest_fifo.size() == 0);
        repeat (300) @(posedge clk);
        if (fail_cnt == 0 && digest_fifo.size() == 0)
          $display("** sha256_byte_stream_hasher_unit: PASSED **");
        else
          $display("** sha256_byte_stream_hasher_unit: FAILED **");
        $finish;
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $error("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
        $display("** sha256_byte_stream_hasher_unit: FAILED **");
        $finish;
      end
    join
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_hmem.sv
rtl/sha256_round.sv
rtl/sha256_byte_stream_hasher_unit.sv
test/tb_top.sv
